[src/htud_pkg.sv]
// Shared types and constants for the host timebase unit detector.
// No dependencies; every other file of the block imports this package.

package htud_pkg;

   // Field widths of the request and response items and the csr port
   localparam int HostW  = 48;
   localparam int TimeW  = 47;
   localparam int FrameW = 20;
   localparam int VoteW  = 8;
   localparam int UnitW  = 2;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 20;

   // Register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CSR_VOTES_NEEDED = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MIN_FRAME    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_FRAME    = 2'd2;

   // Register reset values
   localparam logic [VoteW-1:0]  VOTES_RESET     = 8'd3;
   localparam logic [FrameW-1:0] MIN_FRAME_RESET = 20'd65;
   localparam logic [FrameW-1:0] MAX_FRAME_RESET = 20'd6554;

   // One sixtieth of a second in Q16
   localparam logic [FrameW-1:0] FRAME_DEFAULT = 20'd1092;

   // Host time unit codes
   localparam logic [UnitW-1:0] UNIT_UNDECIDED = 2'd0;
   localparam logic [UnitW-1:0] UNIT_SECONDS   = 2'd1;
   localparam logic [UnitW-1:0] UNIT_MILLIS    = 2'd2;

   // Source of the output time
   localparam logic [1:0] NOW_WALL   = 2'd0;
   localparam logic [1:0] NOW_HOST   = 2'd1;
   localparam logic [1:0] NOW_MILLIS = 2'd2;
   localparam logic [1:0] NOW_ZERO   = 2'd3;

   // Operation codes
   localparam logic OP_TICK       = 1'b0;
   localparam logic OP_SOFT_RESET = 1'b1;

   // wd*2000 >= 65536 holds exactly when wd >= 32.768, so wd >= 33
   localparam logic [TimeW-1:0] WALL_DELTA_MIN = 47'd33;

   // floor(x/1000) = floor((x>>3)/125); (x>>3) < 2^44, so
   // floor(y/125) = (y * ceil(2^51/125)) >> 51
   localparam logic [44:0] DIV125_MUL   = 45'd18014398509482;
   localparam int          DIV125_SHIFT = 51;

   typedef struct packed {
      logic             operation;
      logic [HostW-1:0] host_time;
      logic             host_seen;
      logic [TimeW-1:0] wall_time;
   } req_type;

   // Stage 1: unit decision made, divide split into partial products
   typedef struct packed {
      logic             operation;
      logic [1:0]       now_src;
      logic [TimeW-1:0] host_time;
      logic [TimeW-1:0] wall_time;
      logic [UnitW-1:0] unit;
      logic [44:0]      prod_ll;
      logic [43:0]      prod_lh;
      logic [44:0]      prod_hl;
      logic [43:0]      prod_hh;
   } stage1_type;

   // Stage 2: output time resolved
   typedef struct packed {
      logic             operation;
      logic [TimeW-1:0] now_time;
      logic [UnitW-1:0] unit;
   } stage2_type;

   typedef struct packed {
      logic [VoteW-1:0]  votes_needed;
      logic [FrameW-1:0] min_frame;
      logic [FrameW-1:0] max_frame;
   } cfg_type;

endpackage

[src/htud_vote.sv]
// Unit vote stage: host/wall delta voting, unit latch, now source choice.
// Depends on htud_pkg.

module htud_vote (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  htud_pkg::req_type   req_item,
   input  logic [7:0]          votes_needed,
   output htud_pkg::stage1_type stage_ff
);
   import htud_pkg::*;

   logic [UnitW-1:0] scale_ff, scale_in;
   logic [VoteW-1:0] sec_count_ff, sec_count_in;
   logic [VoteW-1:0] ms_count_ff, ms_count_in;
   logic [TimeW-1:0] prev_host_ff, prev_host_in;
   logic             prev_host_valid_ff, prev_host_valid_in;
   logic [TimeW-1:0] prev_wall_ff, prev_wall_in;
   logic             prev_wall_valid_ff, prev_wall_valid_in;
   stage1_type       stage_in;

   logic             host_ok;
   logic [HostW-1:0] host_delta;
   logic [HostW-1:0] wall_delta;
   logic [TimeW-1:0] hd;
   logic [TimeW-1:0] wd;
   logic             hd_pos;
   logic             wd_ok;
   logic [50:0]      hd_x10;
   logic [50:0]      wd_x10;
   logic [60:0]      wd_x100;
   logic [60:0]      wd_x10000;
   logic             sec_vote;
   logic             ms_vote;
   logic             counting;
   logic             latch;
   logic [43:0]      div_in;

   // Deltas against the previous tick, signed 48 bits
   always_comb begin
      host_ok    = (req_item.operation == OP_TICK) && req_item.host_seen
                   && !req_item.host_time[HostW-1];
      host_delta = {1'b0, req_item.host_time[TimeW-1:0]} - {1'b0, prev_host_ff};
      wall_delta = {1'b0, req_item.wall_time} - {1'b0, prev_wall_ff};
      hd         = host_delta[TimeW-1:0];
      wd         = wall_delta[TimeW-1:0];
      hd_pos     = !host_delta[HostW-1] && (hd != '0);
      wd_ok      = !wall_delta[HostW-1] && (wd >= WALL_DELTA_MIN);
   end

   // Ratio tests by cross-multiplication with constants
   always_comb begin
      hd_x10    = 51'(hd) * 51'd10;
      wd_x10    = 51'(wd) * 51'd10;
      wd_x100   = 61'(wd) * 61'd100;
      wd_x10000 = 61'(wd) * 61'd10000;
      sec_vote  = (hd_x10 > 51'(wd)) && (51'(hd) < wd_x10);
      ms_vote   = !sec_vote && (61'(hd) > wd_x100) && (61'(hd) < wd_x10000);
   end

   // Vote counting and unit latch
   always_comb begin
      counting = host_ok && (scale_ff == UNIT_UNDECIDED) && prev_host_valid_ff
                 && prev_wall_valid_ff && hd_pos && wd_ok;
      sec_count_in = sec_count_ff;
      ms_count_in  = ms_count_ff;
      if (counting && sec_vote && (sec_count_ff != 8'hFF)) begin
         sec_count_in = sec_count_ff + 8'd1;
      end
      if (counting && ms_vote && (ms_count_ff != 8'hFF)) begin
         ms_count_in = ms_count_ff + 8'd1;
      end
      latch = counting && ((sec_count_in >= votes_needed) || (ms_count_in >= votes_needed));
      scale_in = scale_ff;
      if (latch) begin
         scale_in = (ms_count_in > sec_count_in) ? UNIT_MILLIS : UNIT_SECONDS;
      end
   end

   // Previous host and wall times
   always_comb begin
      prev_host_in       = prev_host_ff;
      prev_host_valid_in = prev_host_valid_ff;
      prev_wall_in       = prev_wall_ff;
      prev_wall_valid_in = prev_wall_valid_ff;
      if (host_ok) begin
         prev_host_in       = req_item.host_time[TimeW-1:0];
         prev_host_valid_in = 1'b1;
      end
      if (req_item.operation == OP_TICK) begin
         prev_wall_in       = req_item.wall_time;
         prev_wall_valid_in = 1'b1;
      end
   end

   // Stage register contents: now source and divide partial products
   always_comb begin
      div_in             = req_item.host_time[TimeW-1:3];
      stage_in.operation = req_item.operation;
      stage_in.host_time = req_item.host_time[TimeW-1:0];
      stage_in.wall_time = req_item.wall_time;
      stage_in.unit      = scale_in;
      if (req_item.operation == OP_SOFT_RESET) begin
         stage_in.now_src = NOW_ZERO;
      end else if (!host_ok) begin
         stage_in.now_src = NOW_WALL;
      end else if (scale_in == UNIT_SECONDS) begin
         stage_in.now_src = NOW_HOST;
      end else if (scale_in == UNIT_MILLIS) begin
         stage_in.now_src = NOW_MILLIS;
      end else begin
         stage_in.now_src = NOW_WALL;
      end
      stage_in.prod_ll = 45'(div_in[21:0])  * 45'(DIV125_MUL[22:0]);
      stage_in.prod_lh = 44'(div_in[21:0])  * 44'(DIV125_MUL[44:23]);
      stage_in.prod_hl = 45'(div_in[43:22]) * 45'(DIV125_MUL[22:0]);
      stage_in.prod_hh = 44'(div_in[43:22]) * 44'(DIV125_MUL[44:23]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff           <= UNIT_UNDECIDED;
         sec_count_ff       <= '0;
         ms_count_ff        <= '0;
         prev_host_ff       <= '0;
         prev_host_valid_ff <= 1'b0;
         prev_wall_ff       <= '0;
         prev_wall_valid_ff <= 1'b0;
      end else if (advance) begin
         scale_ff           <= scale_in;
         sec_count_ff       <= sec_count_in;
         ms_count_ff        <= ms_count_in;
         prev_host_ff       <= prev_host_in;
         prev_host_valid_ff <= prev_host_valid_in;
         prev_wall_ff       <= prev_wall_in;
         prev_wall_valid_ff <= prev_wall_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

endmodule

[src/htud_scale.sv]
// Time normalize stage: finishes the divide by 1000 and selects now.
// Depends on htud_pkg.

module htud_scale (
   input  logic                 clock,
   input  logic                 advance,
   input  htud_pkg::stage1_type stage1,
   output htud_pkg::stage2_type stage_ff
);
   import htud_pkg::*;

   logic [88:0] prod_sum;
   logic [TimeW-1:0] millis_time;
   stage2_type stage_in;

   // Recombine the partial products; the quotient sits at bit 51 and up
   always_comb begin
      prod_sum = 89'(stage1.prod_ll)
               + (89'(stage1.prod_lh) << 23)
               + (89'(stage1.prod_hl) << 22)
               + (89'(stage1.prod_hh) << 45);
      millis_time = 47'(prod_sum[88:DIV125_SHIFT]);
   end

   // Output time by source
   always_comb begin
      stage_in.operation = stage1.operation;
      stage_in.unit      = stage1.unit;
      unique case (stage1.now_src)
         NOW_HOST:   stage_in.now_time = stage1.host_time;
         NOW_MILLIS: stage_in.now_time = millis_time;
         NOW_ZERO:   stage_in.now_time = '0;
         default:    stage_in.now_time = stage1.wall_time;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

endmodule

[src/htud_frame.sv]
// Frame stage: clamped frame duration and the response register.
// Depends on htud_pkg.

module htud_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  htud_pkg::stage2_type stage2,
   input  logic [19:0]          min_frame,
   input  logic [19:0]          max_frame,
   output logic [46:0]          now_time_ff,
   output logic [19:0]          frame_time_ff,
   output logic [1:0]           unit_state_ff
);
   import htud_pkg::*;

   logic [TimeW-1:0]  prev_now_ff, prev_now_in;
   logic              prev_now_valid_ff, prev_now_valid_in;
   logic [FrameW-1:0] frame_ff, frame_in;
   logic [TimeW-1:0]  delta;
   logic [TimeW-1:0]  raised;
   logic [TimeW-1:0]  clamped;

   // Forward delta, raised to min then lowered to max
   always_comb begin
      delta   = (stage2.now_time > prev_now_ff) ? (stage2.now_time - prev_now_ff) : '0;
      raised  = (delta < 47'(min_frame)) ? 47'(min_frame) : delta;
      clamped = (raised > 47'(max_frame)) ? 47'(max_frame) : raised;
   end

   always_comb begin
      frame_in          = frame_ff;
      prev_now_in       = prev_now_ff;
      prev_now_valid_in = prev_now_valid_ff;
      if (stage2.operation == OP_SOFT_RESET) begin
         frame_in          = FRAME_DEFAULT;
         prev_now_valid_in = 1'b0;
      end else begin
         if (prev_now_valid_ff) begin
            frame_in = clamped[FrameW-1:0];
         end
         prev_now_in       = stage2.now_time;
         prev_now_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff          <= FRAME_DEFAULT;
         prev_now_ff       <= '0;
         prev_now_valid_ff <= 1'b0;
      end else if (advance) begin
         frame_ff          <= frame_in;
         prev_now_ff       <= prev_now_in;
         prev_now_valid_ff <= prev_now_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         now_time_ff   <= stage2.now_time;
         frame_time_ff <= frame_in;
         unit_state_ff <= stage2.unit;
      end
   end

endmodule

[src/host_timebase_unit_detector_unit.sv]
// Host timebase unit detector, top level.
// Accepts one request per cycle while rsp_ready does not stall the response register.
// Pipeline: input register, vote stage, divide/select stage, frame stage into the
// response register. Each state loop (vote, frame) closes within one stage.
// Reset (synchronous, active high) empties the pipeline, clears votes and history,
// and loads the register defaults and a frame of one sixtieth second.

module host_timebase_unit_detector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [47:0] req_host_time,
   input  logic        req_host_seen,
   input  logic [46:0] req_wall_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [46:0] rsp_now_time,
   output logic [19:0] rsp_frame_time,
   output logic [1:0]  rsp_unit_state,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);
   import htud_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   req_type    s0_item_ff;
   logic       s0_valid_ff, s0_valid_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   stage1_type s1_item;
   stage2_type s2_item;
   logic       take_in, take1, take2, take_out;
   logic       free0, free1, free2, free_out;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_VOTES_NEEDED: cfg_in.votes_needed = csr_data[VoteW-1:0];
            CSR_MIN_FRAME:    cfg_in.min_frame    = csr_data;
            CSR_MAX_FRAME:    cfg_in.max_frame    = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.votes_needed <= VOTES_RESET;
         cfg_ff.min_frame    <= MIN_FRAME_RESET;
         cfg_ff.max_frame    <= MAX_FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline flow: a stage moves when the one after it is empty or moving
   always_comb begin
      free_out = !rsp_valid_ff || rsp_ready;
      take_out = s2_valid_ff && free_out;
      free2    = !s2_valid_ff || take_out;
      take2    = s1_valid_ff && free2;
      free1    = !s1_valid_ff || take2;
      take1    = s0_valid_ff && free1;
      free0    = !s0_valid_ff || take1;
      take_in  = req_valid && free0;

      s0_valid_in  = take_in  || (s0_valid_ff && !take1);
      s1_valid_in  = take1    || (s1_valid_ff && !take2);
      s2_valid_in  = take2    || (s2_valid_ff && !take_out);
      rsp_valid_in = take_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request input register
   always_ff @(posedge clock) begin
      if (take_in) begin
         s0_item_ff.operation <= req_operation;
         s0_item_ff.host_time <= req_host_time;
         s0_item_ff.host_seen <= req_host_seen;
         s0_item_ff.wall_time <= req_wall_time;
      end
   end

   htud_vote u_vote (
      .clock        (clock),
      .reset        (reset),
      .advance      (take1),
      .req_item     (s0_item_ff),
      .votes_needed (cfg_ff.votes_needed),
      .stage_ff     (s1_item)
   );

   htud_scale u_scale (
      .clock    (clock),
      .advance  (take2),
      .stage1   (s1_item),
      .stage_ff (s2_item)
   );

   htud_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .advance       (take_out),
      .stage2        (s2_item),
      .min_frame     (cfg_ff.min_frame),
      .max_frame     (cfg_ff.max_frame),
      .now_time_ff   (rsp_now_time),
      .frame_time_ff (rsp_frame_time),
      .unit_state_ff (rsp_unit_state)
   );

   assign req_ready = free0;
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/htud_checker.sv]
// Port-level checks for the host timebase unit detector, with its bind.
// Depends on htud_pkg and host_timebase_unit_detector_unit.

module htud_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [46:0] rsp_now_time,
   input logic [19:0] rsp_frame_time,
   input logic [1:0]  rsp_unit_state
);
   import htud_pkg::*;

   logic [2:0] inflight_ff, inflight_in;
   logic [1:0] unit_seen_ff, unit_seen_in;
   logic       req_fire;
   logic       rsp_fire;

   // Requests in flight and the first latched unit delivered
   always_comb begin
      req_fire    = req_valid && req_ready;
      rsp_fire    = rsp_valid && rsp_ready;
      inflight_in = inflight_ff + 3'(req_fire) - 3'(rsp_fire);
      unit_seen_in = unit_seen_ff;
      if (rsp_fire && (unit_seen_ff == UNIT_UNDECIDED)) begin
         unit_seen_in = rsp_unit_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= '0;
         unit_seen_ff <= UNIT_UNDECIDED;
      end else begin
         inflight_ff  <= inflight_in;
         unit_seen_ff <= unit_seen_in;
      end
   end

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_now_time)
         && $stable(rsp_frame_time) && $stable(rsp_unit_state))
      else $error("response changed while stalled");

   // No response without an accepted request behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("response without outstanding request");

   // Once a unit is latched it never changes
   a_unit_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (unit_seen_ff != UNIT_UNDECIDED) |-> rsp_unit_state == unit_seen_ff)
      else $error("latched unit changed");

   // Reset leaves the response side empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind host_timebase_unit_detector_unit htud_checker u_htud_checker (.*);
